/* src/imfa_pkg.sv */
// package for the int8 mac fold accumulator
// holds sizing constants, the product beat type and the signed range check
// no dependencies
package imfa_pkg;

  localparam int FOLD       = 16;
  localparam int LOCAL_BITS = 20;
  localparam int MID_BITS   = 32;

  localparam int ACC_W  = 32;
  localparam int DATA_W = 8;
  localparam int PROD_W = 2 * DATA_W;
  localparam int CNT_W  = (FOLD > 1) ? $clog2(FOLD) : 1;
  localparam logic [CNT_W-1:0] FOLD_LAST = CNT_W'(FOLD - 1);

  typedef struct packed {
    logic                     valid;
    logic                     last;
    logic signed [PROD_W-1:0] prod;
  } prod_beat_t;

  // true when v fits the signed range of the given width
  function automatic logic in_range(input logic [ACC_W-1:0] v, input int bits);
    logic [ACC_W:0]   half;
    logic [ACC_W:0]   lim;
    logic [ACC_W-1:0] shifted;
    half    = (ACC_W+1)'(1) << (bits - 1);
    lim     = half << 1;
    shifted = v + half[ACC_W-1:0];
    return (bits >= ACC_W) || ({1'b0, shifted} < lim);
  endfunction

endpackage

/* src/imfa_mul.sv */
// product stage: registers weight times activation with the last mark
// depends on imfa_pkg
module imfa_mul import imfa_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     valid,
  output logic                     stall,
  input  logic signed [DATA_W-1:0] weight,
  input  logic signed [DATA_W-1:0] activation,
  input  logic                     last,
  input  logic                     take,
  output prod_beat_t               beat
);

  assign stall = beat.valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat.valid <= 1'b0;
    end else if (!stall) begin
      beat.valid <= valid;
    end
    if (!stall && valid) begin
      beat.last <= last;
      beat.prod <= weight * activation;
    end
  end

endmodule

/* src/imfa_acc.sv */
// accumulate stage: local and mid sums, fold counter, sticky overflow,
// and the result register; depends on imfa_pkg
module imfa_acc import imfa_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  prod_beat_t              beat,
  output logic                    take,
  output logic                    res_valid,
  input  logic                    res_stall,
  output logic signed [ACC_W-1:0] sum,
  output logic                    overflow
);

  logic [ACC_W-1:0] local_sum;
  logic [ACC_W-1:0] mid_sum;
  logic [CNT_W-1:0] fold_count;
  logic             overflow_seen;

  logic [ACC_W-1:0] prod_ext;
  logic [ACC_W-1:0] local_next;
  logic [ACC_W-1:0] total;
  logic             fold_done;
  logic             overflow_next;

  assign take = beat.valid && (!beat.last || !res_valid || !res_stall);

  always_comb begin
    prod_ext      = ACC_W'(beat.prod);
    local_next    = local_sum + prod_ext;
    total         = mid_sum + local_next;
    fold_done     = (fold_count == FOLD_LAST);
    overflow_next = overflow_seen || !in_range(local_next, LOCAL_BITS)
                    || (fold_done && !in_range(total, MID_BITS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      local_sum     <= '0;
      mid_sum       <= '0;
      fold_count    <= '0;
      overflow_seen <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      if (take && beat.last) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      if (take) begin
        if (beat.last) begin
          local_sum     <= '0;
          mid_sum       <= '0;
          fold_count    <= '0;
          overflow_seen <= 1'b0;
        end else begin
          overflow_seen <= overflow_next;
          if (fold_done) begin
            mid_sum    <= total;
            local_sum  <= '0;
            fold_count <= '0;
          end else begin
            local_sum  <= local_next;
            fold_count <= fold_count + CNT_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && beat.last) begin
      sum      <= total;
      overflow <= overflow_next;
    end
  end

endmodule

/* src/int8_mac_fold_accumulator.sv */
// int8 mac fold accumulator, top level
// result path: a last beat passes the product register, then the sum and overflow registers
// throughput: one beat per cycle; a last beat waits only while the previous result is stalled
// reset: synchronous rst clears local and mid sums, fold counter, sticky overflow flag and valids
// depends on imfa_pkg, imfa_mul, imfa_acc
module int8_mac_fold_accumulator import imfa_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     valid,
  output logic                     stall,
  input  logic signed [DATA_W-1:0] weight,
  input  logic signed [DATA_W-1:0] activation,
  input  logic                     last,
  output logic                     res_valid,
  input  logic                     res_stall,
  output logic signed [ACC_W-1:0]  sum,
  output logic                     overflow
);

  prod_beat_t prod_beat;
  logic       take;

  imfa_mul u_mul (
    .clk        (clk),
    .rst        (rst),
    .valid      (valid),
    .stall      (stall),
    .weight     (weight),
    .activation (activation),
    .last       (last),
    .take       (take),
    .beat       (prod_beat)
  );

  imfa_acc u_acc (
    .clk       (clk),
    .rst       (rst),
    .beat      (prod_beat),
    .take      (take),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .sum       (sum),
    .overflow  (overflow)
  );

`ifndef SYNTHESIS
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    stall |-> prod_beat.valid)
    else $error("input stalled with empty product stage");

  a_last_waits_result: assert property (@(posedge clk) disable iff (rst)
    (prod_beat.valid && prod_beat.last && res_valid && res_stall) |-> stall)
    else $error("last beat taken while result blocked");

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(prod_beat.valid && prod_beat.last))
    else $error("result without a last beat");
`endif

endmodule

/* tb/tb_int8_mac_fold_accumulator.sv */
// testbench for int8_mac_fold_accumulator: directed and random product streams
// checks each emitted sum and overflow flag against an in-bench accumulator model
// depends on imfa_pkg and the int8_mac_fold_accumulator rtl
module tb_int8_mac_fold_accumulator;
  import imfa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_LIMIT = 400000;

  typedef struct {
    logic signed [ACC_W-1:0] sum;
    logic                    overflow;
  } dot_result_t;

  logic                     clk;
  logic                     rst;
  logic                     valid;
  logic                     stall;
  logic signed [DATA_W-1:0] weight;
  logic signed [DATA_W-1:0] activation;
  logic                     last;
  logic                     res_valid;
  logic                     res_stall;
  logic signed [ACC_W-1:0]  sum;
  logic                     overflow;

  int unsigned sender_idle_pct   = 0;
  int unsigned receiver_idle_pct = 0;
  int unsigned cycle_count       = 0;
  int unsigned items_sent        = 0;
  int unsigned dots_sent         = 0;
  int unsigned results_seen      = 0;
  int unsigned error_count       = 0;

  dot_result_t expected_q[$];
  dot_result_t exp_res;

  // bench model state
  logic [ACC_W-1:0] m_local = '0;
  logic [ACC_W-1:0] m_mid   = '0;
  int unsigned      m_count = 0;
  logic             m_ovf   = 1'b0;

  int8_mac_fold_accumulator u_dut (
    .clk        (clk),
    .rst        (rst),
    .valid      (valid),
    .stall      (stall),
    .weight     (weight),
    .activation (activation),
    .last       (last),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .sum        (sum),
    .overflow   (overflow)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(negedge clk) begin
    res_stall = ($urandom_range(99) < receiver_idle_pct);
  end

  task automatic report_mismatch(input string what);
    error_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  function automatic bit fits(input logic [ACC_W-1:0] v, input int bits);
    longint value;
    longint bound;
    if (bits >= ACC_W) begin
      return 1'b1;
    end
    value = longint'($signed(v));
    bound = longint'(1) << (bits - 1);
    return (value >= -bound) && (value < bound);
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_operand();
    int unsigned pick;
    pick = $urandom_range(7);
    if (pick == 0) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else if (pick == 1) begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
    return DATA_W'($urandom());
  endfunction

  task automatic model_step(input logic signed [DATA_W-1:0] w,
                            input logic signed [DATA_W-1:0] a,
                            input logic l);
    logic signed [ACC_W-1:0] prod;
    dot_result_t             r;
    prod    = ACC_W'(w) * ACC_W'(a);
    m_local = m_local + prod;
    if (!fits(m_local, LOCAL_BITS)) begin
      m_ovf = 1'b1;
    end
    m_count++;
    if (m_count >= FOLD) begin
      m_mid = m_mid + m_local;
      if (!fits(m_mid, MID_BITS)) begin
        m_ovf = 1'b1;
      end
      m_local = '0;
      m_count = 0;
    end
    if (l) begin
      r.sum      = m_mid + m_local;
      r.overflow = m_ovf;
      expected_q.push_back(r);
      dots_sent++;
      m_local = '0;
      m_mid   = '0;
      m_count = 0;
      m_ovf   = 1'b0;
    end
  endtask

  // entered and left at a falling edge
  task automatic send_item(input logic signed [DATA_W-1:0] w,
                           input logic signed [DATA_W-1:0] a,
                           input logic l);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
    end
    valid      = 1'b1;
    weight     = w;
    activation = a;
    last       = l;
    @(posedge clk);
    while (stall) begin
      @(posedge clk);
    end
    model_step(w, a, l);
    items_sent++;
    @(negedge clk);
    valid = 1'b0;
  endtask

  task automatic send_random_dot(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_item(rand_operand(), rand_operand(), (i == len - 1));
    end
  endtask

  task automatic wait_drain();
    while (expected_q.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic test_single_product();
    send_item(-8'sd3, 8'sd7, 1'b1);
  endtask

  task automatic test_short_dot();
    send_random_dot(10);
  endtask

  task automatic test_fold_edges();
    send_random_dot((FOLD > 1) ? FOLD - 1 : 1);
    send_random_dot(FOLD);
    send_random_dot(FOLD + 1);
    send_random_dot(2 * FOLD);
    send_random_dot(1);
  endtask

  task automatic test_extreme_products();
    int unsigned len;
    len = 3 * FOLD + 5;
    for (int unsigned i = 0; i < len; i++) begin
      send_item({1'b1, {(DATA_W-1){1'b0}}}, {1'b1, {(DATA_W-1){1'b0}}}, (i == len - 1));
    end
    len = 2 * FOLD + 3;
    for (int unsigned i = 0; i < len; i++) begin
      send_item({1'b1, {(DATA_W-1){1'b0}}}, {1'b0, {(DATA_W-1){1'b1}}}, (i == len - 1));
    end
  endtask

  task automatic test_drain();
    send_random_dot(20);
    send_random_dot(20);
    wait_drain();
    send_random_dot(1);
  endtask

  task automatic test_random_stream(input int unsigned quota);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < quota) begin
      send_random_dot($urandom_range(3 * FOLD, 1));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result sum %0d overflow %0b", sum, overflow));
      end else begin
        exp_res = expected_q.pop_front();
        if (sum !== exp_res.sum || overflow !== exp_res.overflow) begin
          report_mismatch($sformatf("got sum %0d overflow %0b, expected sum %0d overflow %0b",
                                    sum, overflow, exp_res.sum, exp_res.overflow));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("run stopped at cycle limit with %0d results outstanding", expected_q.size());
      $display("int8_mac_fold_accumulator: mismatch");
      $finish;
    end
  end

  initial begin
    rst        = 1'b1;
    valid      = 1'b0;
    weight     = '0;
    activation = '0;
    last       = 1'b0;
    sender_idle_pct   = 17;
    receiver_idle_pct = 48;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_single_product();
    test_short_dot();
    test_fold_edges();
    test_random_stream(440);

    sender_idle_pct   = 48;
    receiver_idle_pct = 17;
    test_drain();
    test_random_stream(440);

    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    test_extreme_products();
    test_random_stream(440);

    wait_drain();
    repeat (4) @(negedge clk);

    $display("covered %0d beats in %0d dot products, %0d results checked", items_sent,
             dots_sent, results_seen);
    $display("fold edges, extreme operands, a full drain and three idle mixes were exercised");
    if (error_count == 0) begin
      $display("int8_mac_fold_accumulator: match");
    end else begin
      $display("int8_mac_fold_accumulator: mismatch");
    end
    $finish;
  end

endmodule
